@@ rtl/core/lav_pkg.sv @@
// Shared types and constants of the look-at view matrix core.
// No dependencies; every other file of the core imports this package.
package lav_pkg;

	localparam int COORD_W   = 32;
	localparam int DIR_W     = COORD_W + 1;
	localparam int CROSS_W   = 64;
	localparam int AXIS_W    = 32;
	localparam int AXIS_FRAC = 30;

	// Normalizer: 6 setup stages, 31 square root steps, 1 numerator stage,
	// 31 divide steps and 1 sign stage.
	localparam int NORM_LAT  = 70;

	localparam int QDEPTH    = 4;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] look_x;
		logic signed [31:0] look_y;
		logic signed [31:0] look_z;
		logic signed [31:0] upvec_x;
		logic signed [31:0] upvec_y;
		logic signed [31:0] upvec_z;
	} lav_in_t;

	typedef struct packed {
		logic signed [31:0] right_x;
		logic signed [31:0] right_y;
		logic signed [31:0] right_z;
		logic signed [31:0] cam_up_x;
		logic signed [31:0] cam_up_y;
		logic signed [31:0] cam_up_z;
		logic signed [31:0] forward_x;
		logic signed [31:0] forward_y;
		logic signed [31:0] forward_z;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
	} lav_res_t;

	// Item handed from the front end to the back end.
	typedef struct packed {
		logic [2:0][COORD_W-1:0] eye;
		logic [2:0][COORD_W-1:0] up;
		logic [2:0][DIR_W-1:0]   dir;
		logic                    dir_zero;
	} lav_item_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] eye;
		logic [2:0][COORD_W-1:0] up;
		logic                    kill;
	} lav_side_a_t;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] eye;
		logic [2:0][AXIS_W-1:0]  fwd;
		logic                    kill;
	} lav_side_b_t;

	// Number of significant bits of an 8-bit value.
	function automatic logic [3:0] bitlen8(input logic [7:0] x);
		logic [3:0] r;
		r = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (x[i]) begin
				r = 4'(i + 1);
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/core/look_at_view_matrix_core.sv @@
// Top level of the left-handed look-at view matrix core.
// Depends on lav_pkg, lav_front, lav_fifo and lav_back (with lav_norm).
//
//   Channel   Handshake            Payload    Beat moves
//   input     push / full          item       eye, target and up hint, Q16.16
//   result    empty / pop          result     three unit axes Q2.30, translation
//
// The core accepts one beat per cycle and returns one result per cycle in a
// steady stream while each result is popped. Each beat passes through the two
// normalizers, each of which spends 31 stages on the square root and 31 on
// the dividers, plus the cross product and dot product stages.
// Reset clears only valid flags and queue pointers; no clearing pass is needed.
// When the result is not popped the whole back pipeline holds, while the front
// end keeps taking beats until its register and the four-entry queue are full.
//
// The front end registers each beat, forms target minus eye and flags a zero
// direction. The back end normalizes the direction, forms up x forward and
// normalizes it into the right axis, forms forward x right for the camera up
// axis and finally the three translation terms. A zero direction or a zero
// right axis turns the whole result into zeros.
module look_at_view_matrix_core
	import lav_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  lav_in_t  item,
	output logic     empty,
	input  logic     pop,
	output lav_res_t result
);

	logic      q_wr;
	logic      q_full;
	lav_item_t q_wdata;
	logic      q_rd;
	logic      q_empty;
	lav_item_t q_rdata;

	// Front end: accept and classify.
	lav_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_data (q_wdata)
	);

	// Short queue that lets the front end keep accepting during a stall.
	lav_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Back end: the arithmetic pipeline; its last stage is the result register.
	lav_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.q_data  (q_rdata),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

@@ rtl/core/lav_fifo.sv @@
// Four-entry queue between the front end and the back end.
// Depends on lav_pkg for the item type and the depth.
module lav_fifo
	import lav_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  lav_item_t wdata,
	output logic      full,
	input  logic      rd,
	output lav_item_t rdata,
	output logic      empty
);

	localparam int PTR_W = $clog2(QDEPTH);

	lav_item_t        mem_q [QDEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == (PTR_W + 1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/core/lav_front.sv @@
// Front end: takes camera beats, forms the view direction and flags a
// zero direction, then hands the item to the queue. Depends on lav_pkg.
module lav_front
	import lav_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  lav_in_t   item,
	input  logic      q_full,
	output logic      q_wr,
	output lav_item_t q_data
);

	lav_item_t  f_s1;
	logic       fv_s1;
	logic       adv;
	lav_item_t  f_c;

	assign adv    = !fv_s1 || !q_full;
	assign full   = !adv;
	assign q_wr   = fv_s1;
	assign q_data = f_s1;

	always_comb begin
		f_c.eye[0] = item.eye_x;
		f_c.eye[1] = item.eye_y;
		f_c.eye[2] = item.eye_z;
		f_c.up[0]  = item.upvec_x;
		f_c.up[1]  = item.upvec_y;
		f_c.up[2]  = item.upvec_z;
		f_c.dir[0] = DIR_W'(item.look_x) - DIR_W'(item.eye_x);
		f_c.dir[1] = DIR_W'(item.look_y) - DIR_W'(item.eye_y);
		f_c.dir[2] = DIR_W'(item.look_z) - DIR_W'(item.eye_z);
		f_c.dir_zero = (item.look_x == item.eye_x) && (item.look_y == item.eye_y)
			&& (item.look_z == item.eye_z);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1 <= f_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s1 <= 1'b0;
		end else if (adv) begin
			fv_s1 <= push;
		end
	end

endmodule

@@ rtl/core/lav_norm.sv @@
// Pipelined vector normalizer: block scaling, square root and three dividers,
// one step per stage. Depends on lav_pkg.
module lav_norm
	import lav_pkg::*;
#(
	parameter int W = 33
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [2:0][W-1:0]      vec,
	output logic [2:0][AXIS_W-1:0] unit,
	output logic                   zero
);

	localparam int GRP   = (W + 7) / 8;
	localparam int GRP_W = (GRP > 1) ? $clog2(GRP) : 1;
	localparam int PW    = GRP * 8;
	localparam int BL_W  = $clog2(PW + 1);
	localparam int MW    = AXIS_FRAC;
	localparam int SUM_W = 2 * AXIS_FRAC + 2;
	localparam int ISQ_N = AXIS_FRAC + 1;
	localparam int LEN_W = AXIS_FRAC + 1;
	localparam int NUM_W = 2 * AXIS_FRAC + 1;
	localparam int DIV_N = AXIS_FRAC + 1;
	localparam int MZ_N  = ISQ_N + 3;

	logic [2:0][W-1:0]     mag_s1, mag_s2, mag_s3;
	logic [2:0]            sgn_s1, sgn_s2, sgn_s3;
	logic [GRP_W-1:0]      grp_s2;
	logic [7:0]            oct_s2;
	logic                  nz_s2, nz_s3;
	logic [BL_W-1:0]       bl_s3;
	logic [PW-1:0]         orw_c;
	logic [GRP_W-1:0]      grp_c;
	logic [7:0]            oct_c;
	logic [2:0][W+MW-1:0]  sh_c;

	logic [2:0][MW-1:0]    mm_s [MZ_N];
	logic [2:0]            ms_s [MZ_N];
	logic                  mn_s [MZ_N];
	logic [2:0][2*MW-1:0]  sq_s5;

	logic [SUM_W-1:0]      isv_s [ISQ_N+1];
	logic [SUM_W-1:0]      isr_s [ISQ_N+1];
	logic [SUM_W-1:0]      ibit_c [ISQ_N];
	logic [SUM_W:0]        itry_c [ISQ_N];
	logic                  ige_c [ISQ_N];

	logic [2:0][NUM_W-1:0] nn_c;
	logic [2:0][NUM_W-1:0] dn_s [DIV_N+1];
	logic [2:0][LEN_W-1:0] dr_s [DIV_N+1];
	logic [2:0][DIV_N-1:0] dq_s [DIV_N+1];
	logic [LEN_W-1:0]      dl_s [DIV_N+1];
	logic [2:0]            dsg_s [DIV_N+1];
	logic                  dnz_s [DIV_N+1];
	logic [2:0][LEN_W:0]   dt_c [DIV_N];
	logic [2:0]            dge_c [DIV_N];

	// Bit length of the largest magnitude equals that of the OR of all three.
	always_comb begin
		orw_c = PW'(mag_s1[0] | mag_s1[1] | mag_s1[2]);
		grp_c = '0;
		oct_c = '0;
		for (int g = 0; g < GRP; g++) begin
			if (orw_c[g*8 +: 8] != 8'd0) begin
				grp_c = GRP_W'(g);
				oct_c = orw_c[g*8 +: 8];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh_c[i] = {mag_s3[i], MW'(0)} >> bl_s3;
		end
	end

	always_comb begin
		for (int k = 0; k < ISQ_N; k++) begin
			ibit_c[k] = SUM_W'(1) << (SUM_W - 2 - 2 * k);
			itry_c[k] = (SUM_W + 1)'(isr_s[k]) + (SUM_W + 1)'(ibit_c[k]);
			ige_c[k]  = ({1'b0, isv_s[k]} >= itry_c[k]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nn_c[i] = NUM_W'({mm_s[MZ_N-1][i], MW'(0)})
				+ NUM_W'(isr_s[ISQ_N][LEN_W-1:1]);
		end
		for (int j = 0; j < DIV_N; j++) begin
			for (int i = 0; i < 3; i++) begin
				dt_c[j][i]  = {dr_s[j][i], dn_s[j][i][DIV_N-1-j]};
				dge_c[j][i] = (dt_c[j][i] >= {1'b0, dl_s[j]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sgn_s1[i] <= vec[i][W-1];
				mag_s1[i] <= vec[i][W-1] ? (~vec[i] + W'(1)) : vec[i];
			end
			mag_s2 <= mag_s1;
			sgn_s2 <= sgn_s1;
			grp_s2 <= grp_c;
			oct_s2 <= oct_c;
			nz_s2  <= (orw_c != '0);
			mag_s3 <= mag_s2;
			sgn_s3 <= sgn_s2;
			nz_s3  <= nz_s2;
			bl_s3  <= BL_W'({grp_s2, 3'b000}) + BL_W'(bitlen8(oct_s2));

			for (int i = 0; i < 3; i++) begin
				mm_s[0][i] <= sh_c[i][MW-1:0];
			end
			ms_s[0] <= sgn_s3;
			mn_s[0] <= nz_s3;
			for (int j = 1; j < MZ_N; j++) begin
				mm_s[j] <= mm_s[j-1];
				ms_s[j] <= ms_s[j-1];
				mn_s[j] <= mn_s[j-1];
			end

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= mm_s[0][i] * mm_s[0][i];
			end
			isv_s[0] <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
			isr_s[0] <= '0;
			for (int k = 0; k < ISQ_N; k++) begin
				isv_s[k+1] <= ige_c[k] ? SUM_W'(isv_s[k] - itry_c[k][SUM_W-1:0]) : isv_s[k];
				isr_s[k+1] <= (isr_s[k] >> 1) + (ige_c[k] ? ibit_c[k] : SUM_W'(0));
			end

			for (int i = 0; i < 3; i++) begin
				dn_s[0][i] <= nn_c[i];
				dr_s[0][i] <= LEN_W'(nn_c[i][NUM_W-1:DIV_N]);
				dq_s[0][i] <= '0;
			end
			dl_s[0]  <= isr_s[ISQ_N][LEN_W-1:0];
			dsg_s[0] <= ms_s[MZ_N-1];
			dnz_s[0] <= mn_s[MZ_N-1];
			for (int j = 0; j < DIV_N; j++) begin
				for (int i = 0; i < 3; i++) begin
					dr_s[j+1][i] <= dge_c[j][i] ? LEN_W'(dt_c[j][i] - {1'b0, dl_s[j]})
						: LEN_W'(dt_c[j][i]);
					dq_s[j+1][i] <= {dq_s[j][i][DIV_N-2:0], dge_c[j][i]};
				end
				dn_s[j+1]  <= dn_s[j];
				dl_s[j+1]  <= dl_s[j];
				dsg_s[j+1] <= dsg_s[j];
				dnz_s[j+1] <= dnz_s[j];
			end

			for (int i = 0; i < 3; i++) begin
				unit[i] <= dsg_s[DIV_N][i] ? (~AXIS_W'(dq_s[DIV_N][i]) + AXIS_W'(1))
					: AXIS_W'(dq_s[DIV_N][i]);
			end
			zero <= !dnz_s[DIV_N];
		end
	end

endmodule

@@ rtl/core/lav_back.sv @@
// Back end: forward axis, right axis, camera up axis and translation, all in
// one stall-together pipeline. Depends on lav_pkg and lav_norm.
module lav_back
	import lav_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	output logic      q_rd,
	input  lav_item_t q_data,
	output logic      empty,
	input  logic      pop,
	output lav_res_t  result
);

	logic adv;

	lav_item_t   in_s1;
	logic        v_s1;
	lav_side_a_t lna_s [NORM_LAT];
	logic        vla_s [NORM_LAT];
	logic [2:0][AXIS_W-1:0] fwd_n;
	logic        zero1;

	logic signed [63:0]     px_s2 [6];
	logic [2:0][COORD_W-1:0] eye_s2, eye_s3;
	logic [2:0][AXIS_W-1:0]  fwd_s2, fwd_s3;
	logic                   kill_s2, kill_s3, v_s2, v_s3;
	logic [2:0][CROSS_W-1:0] rc_s3;

	lav_side_b_t lnb_s [NORM_LAT];
	logic        vlb_s [NORM_LAT];
	logic [2:0][AXIS_W-1:0] right_n;
	logic        zero2;

	logic signed [63:0] pu_s4 [6];
	logic signed [63:0] pr_s4 [3];
	logic signed [63:0] pf_s4 [3];
	logic signed [63:0] uc_s5 [3];
	logic signed [63:0] dr_s5, df_s5;
	logic [34:0]        ucm_s6 [3];
	logic [2:0]         ucn_s6;
	logic [34:0]        drm_s6, dfm_s6;
	logic               drn_s6, dfn_s6;
	logic [2:0][AXIS_W-1:0] cup_s7, cup_s8, cup_s9, cup_s10;
	logic [31:0]        sx_s7, sz_s7, sx_s8, sz_s8, sx_s9, sz_s9, sx_s10, sz_s10;
	logic signed [63:0] pc_s8 [3];
	logic signed [63:0] dc_s9;
	logic [34:0]        dcm_s10;
	logic               dcn_s10;

	logic [2:0][AXIS_W-1:0] right_s4, right_s5, right_s6, right_s7;
	logic [2:0][AXIS_W-1:0] right_s8, right_s9, right_s10;
	logic [2:0][AXIS_W-1:0] fwd_s4, fwd_s5, fwd_s6, fwd_s7, fwd_s8, fwd_s9, fwd_s10;
	logic [2:0][COORD_W-1:0] eye_s4, eye_s5, eye_s6, eye_s7;
	logic kill_s4, kill_s5, kill_s6, kill_s7, kill_s8, kill_s9, kill_s10;
	logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	lav_res_t res_s11;

	// Magnitude of x shifted right by AXIS_FRAC, half rounded away from zero.
	function automatic logic [34:0] rnd_mag(input logic signed [63:0] x);
		logic [63:0] m;
		m = x[63] ? 64'(-x) : 64'(x);
		return 35'((m + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC);
	endfunction

	function automatic logic [31:0] clamp_axis(input logic neg, input logic [34:0] m);
		logic [34:0] c;
		c = (m > (35'd1 << AXIS_FRAC)) ? (35'd1 << AXIS_FRAC) : m;
		return neg ? (~c[31:0] + 32'd1) : c[31:0];
	endfunction

	function automatic logic [31:0] sat_shift(input logic neg, input logic [34:0] m);
		logic [31:0] r;
		if (neg) begin
			r = (m >= 35'h0_8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
		end else begin
			r = (m > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		end
		return r;
	endfunction

	assign adv   = !v_s11 || pop;
	assign q_rd  = adv && !q_empty;
	assign empty = !v_s11;
	assign result = res_s11;

	lav_norm #(.W(DIR_W)) u_norm_fwd (
		.clk  (clk),
		.en   (adv),
		.vec  (in_s1.dir),
		.unit (fwd_n),
		.zero (zero1)
	);

	lav_norm #(.W(CROSS_W)) u_norm_right (
		.clk  (clk),
		.en   (adv),
		.vec  (rc_s3),
		.unit (right_n),
		.zero (zero2)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1 <= q_data;

			lna_s[0].eye  <= in_s1.eye;
			lna_s[0].up   <= in_s1.up;
			lna_s[0].kill <= in_s1.dir_zero;
			for (int k = 1; k < NORM_LAT; k++) begin
				lna_s[k] <= lna_s[k-1];
			end

			// up x forward
			px_s2[0] <= $signed(lna_s[NORM_LAT-1].up[1]) * $signed(fwd_n[2]);
			px_s2[1] <= $signed(lna_s[NORM_LAT-1].up[2]) * $signed(fwd_n[1]);
			px_s2[2] <= $signed(lna_s[NORM_LAT-1].up[2]) * $signed(fwd_n[0]);
			px_s2[3] <= $signed(lna_s[NORM_LAT-1].up[0]) * $signed(fwd_n[2]);
			px_s2[4] <= $signed(lna_s[NORM_LAT-1].up[0]) * $signed(fwd_n[1]);
			px_s2[5] <= $signed(lna_s[NORM_LAT-1].up[1]) * $signed(fwd_n[0]);
			eye_s2  <= lna_s[NORM_LAT-1].eye;
			fwd_s2  <= fwd_n;
			kill_s2 <= lna_s[NORM_LAT-1].kill || zero1;

			for (int i = 0; i < 3; i++) begin
				rc_s3[i] <= CROSS_W'(px_s2[2*i] - px_s2[2*i+1]);
			end
			eye_s3  <= eye_s2;
			fwd_s3  <= fwd_s2;
			kill_s3 <= kill_s2;

			lnb_s[0].eye  <= eye_s3;
			lnb_s[0].fwd  <= fwd_s3;
			lnb_s[0].kill <= kill_s3;
			for (int k = 1; k < NORM_LAT; k++) begin
				lnb_s[k] <= lnb_s[k-1];
			end

			// forward x right, and the right and forward dot products with eye
			pu_s4[0] <= $signed(lnb_s[NORM_LAT-1].fwd[1]) * $signed(right_n[2]);
			pu_s4[1] <= $signed(lnb_s[NORM_LAT-1].fwd[2]) * $signed(right_n[1]);
			pu_s4[2] <= $signed(lnb_s[NORM_LAT-1].fwd[2]) * $signed(right_n[0]);
			pu_s4[3] <= $signed(lnb_s[NORM_LAT-1].fwd[0]) * $signed(right_n[2]);
			pu_s4[4] <= $signed(lnb_s[NORM_LAT-1].fwd[0]) * $signed(right_n[1]);
			pu_s4[5] <= $signed(lnb_s[NORM_LAT-1].fwd[1]) * $signed(right_n[0]);
			for (int i = 0; i < 3; i++) begin
				pr_s4[i] <= $signed(right_n[i]) * $signed(lnb_s[NORM_LAT-1].eye[i]);
				pf_s4[i] <= $signed(lnb_s[NORM_LAT-1].fwd[i])
					* $signed(lnb_s[NORM_LAT-1].eye[i]);
			end
			right_s4 <= right_n;
			fwd_s4   <= lnb_s[NORM_LAT-1].fwd;
			eye_s4   <= lnb_s[NORM_LAT-1].eye;
			kill_s4  <= lnb_s[NORM_LAT-1].kill || zero2;

			for (int i = 0; i < 3; i++) begin
				uc_s5[i] <= pu_s4[2*i] - pu_s4[2*i+1];
			end
			dr_s5    <= pr_s4[0] + pr_s4[1] + pr_s4[2];
			df_s5    <= pf_s4[0] + pf_s4[1] + pf_s4[2];
			right_s5 <= right_s4;
			fwd_s5   <= fwd_s4;
			eye_s5   <= eye_s4;
			kill_s5  <= kill_s4;

			for (int i = 0; i < 3; i++) begin
				ucm_s6[i] <= rnd_mag(uc_s5[i]);
				ucn_s6[i] <= uc_s5[i][63];
			end
			drm_s6   <= rnd_mag(dr_s5);
			dfm_s6   <= rnd_mag(df_s5);
			drn_s6   <= !dr_s5[63];
			dfn_s6   <= !df_s5[63];
			right_s6 <= right_s5;
			fwd_s6   <= fwd_s5;
			eye_s6   <= eye_s5;
			kill_s6  <= kill_s5;

			for (int i = 0; i < 3; i++) begin
				cup_s7[i] <= clamp_axis(ucn_s6[i], ucm_s6[i]);
			end
			sx_s7    <= sat_shift(drn_s6, drm_s6);
			sz_s7    <= sat_shift(dfn_s6, dfm_s6);
			right_s7 <= right_s6;
			fwd_s7   <= fwd_s6;
			eye_s7   <= eye_s6;
			kill_s7  <= kill_s6;

			for (int i = 0; i < 3; i++) begin
				pc_s8[i] <= $signed(cup_s7[i]) * $signed(eye_s7[i]);
			end
			cup_s8   <= cup_s7;
			sx_s8    <= sx_s7;
			sz_s8    <= sz_s7;
			right_s8 <= right_s7;
			fwd_s8   <= fwd_s7;
			kill_s8  <= kill_s7;

			dc_s9    <= pc_s8[0] + pc_s8[1] + pc_s8[2];
			cup_s9   <= cup_s8;
			sx_s9    <= sx_s8;
			sz_s9    <= sz_s8;
			right_s9 <= right_s8;
			fwd_s9   <= fwd_s8;
			kill_s9  <= kill_s8;

			dcm_s10   <= rnd_mag(dc_s9);
			dcn_s10   <= !dc_s9[63];
			cup_s10   <= cup_s9;
			sx_s10    <= sx_s9;
			sz_s10    <= sz_s9;
			right_s10 <= right_s9;
			fwd_s10   <= fwd_s9;
			kill_s10  <= kill_s9;

			if (kill_s10) begin
				res_s11 <= '0;
			end else begin
				res_s11.right_x   <= right_s10[0];
				res_s11.right_y   <= right_s10[1];
				res_s11.right_z   <= right_s10[2];
				res_s11.cam_up_x  <= cup_s10[0];
				res_s11.cam_up_y  <= cup_s10[1];
				res_s11.cam_up_z  <= cup_s10[2];
				res_s11.forward_x <= fwd_s10[0];
				res_s11.forward_y <= fwd_s10[1];
				res_s11.forward_z <= fwd_s10[2];
				res_s11.shift_x   <= sx_s10;
				res_s11.shift_y   <= sat_shift(dcn_s10, dcm_s10);
				res_s11.shift_z   <= sz_s10;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k < NORM_LAT; k++) begin
				vla_s[k] <= 1'b0;
				vlb_s[k] <= 1'b0;
			end
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s1     <= !q_empty;
			vla_s[0] <= v_s1;
			for (int k = 1; k < NORM_LAT; k++) begin
				vla_s[k] <= vla_s[k-1];
			end
			v_s2     <= vla_s[NORM_LAT-1];
			v_s3     <= v_s2;
			vlb_s[0] <= v_s3;
			for (int k = 1; k < NORM_LAT; k++) begin
				vlb_s[k] <= vlb_s[k-1];
			end
			v_s4  <= vlb_s[NORM_LAT-1];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

endmodule
